// File: rtl/clock_time_setting_editor_unit_defines.svh
// Assertion macros shared by the clock time setting editor RTL.
// Both forms check at the rising edge of clk; the first is masked while
// rst_n is low, the second also covers the reset cycles.
`ifndef CLOCK_TIME_SETTING_EDITOR_UNIT_DEFINES_SVH
`define CLOCK_TIME_SETTING_EDITOR_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

`define CTSE_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("clock time setting editor: assertion failed");

`define CTSE_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("clock time setting editor: assertion failed");

`else

`define CTSE_ASSERT(label, prop)

`define CTSE_ASSERT_ALWAYS(label, prop)

`endif

`endif

// File: rtl/ctse_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ctse_pkg;

  // Year span of the editor.
  localparam logic [11:0] FIRST_YEAR = 12'd1900;
  localparam logic [11:0] LAST_YEAR  = 12'd2100;

  // Century years in the span that are not leap years.
  localparam logic [11:0] NOLEAP_CENTURY_LO = 12'd1900;
  localparam logic [11:0] NOLEAP_CENTURY_HI = 12'd2100;

  localparam logic [3:0] FIRST_MONTH = 4'd1;
  localparam logic [3:0] LAST_MONTH  = 4'd12;
  localparam logic [4:0] FIRST_DAY   = 5'd1;
  localparam logic [4:0] LAST_HOUR   = 5'd23;
  localparam logic [4:0] NOON_HOUR   = 5'd12;
  localparam logic [5:0] LAST_MINSEC = 6'd59;

  // Input and output packed beat widths.
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 48;

  // Key commands.
  typedef enum logic [2:0] {
    CMD_LOAD = 3'd0,
    CMD_NEXT = 3'd1,
    CMD_INC  = 3'd2,
    CMD_DEC  = 3'd3,
    CMD_SAVE = 3'd4
  } cmd_t;

  // Cursor codes.
  localparam logic [2:0] FLD_HOUR   = 3'd0;
  localparam logic [2:0] FLD_MINUTE = 3'd1;
  localparam logic [2:0] FLD_SECOND = 3'd2;
  localparam logic [2:0] FLD_YEAR   = 3'd3;
  localparam logic [2:0] FLD_MONTH  = 3'd4;
  localparam logic [2:0] FLD_DAY    = 3'd5;

  // Gregorian rule, reduced to the year span: a multiple of four is a leap
  // year unless it is one of the century years that are not.
  function automatic logic leap_year(input logic [11:0] y);
    return (y[1:0] == 2'b00) && (y != NOLEAP_CENTURY_LO) && (y != NOLEAP_CENTURY_HI);
  endfunction

  // Month length table; a month code outside 1..12 gives 31.
  function automatic logic [4:0] days_of(input logic [11:0] y, input logic [3:0] m);
    logic [4:0] d;
    case (m)
      4'd1:    d = 5'd31;
      4'd2:    d = leap_year(y) ? 5'd29 : 5'd28;
      4'd3:    d = 5'd31;
      4'd4:    d = 5'd30;
      4'd5:    d = 5'd31;
      4'd6:    d = 5'd30;
      4'd7:    d = 5'd31;
      4'd8:    d = 5'd31;
      4'd9:    d = 5'd30;
      4'd10:   d = 5'd31;
      4'd11:   d = 5'd30;
      4'd12:   d = 5'd31;
      default: d = 5'd31;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

// File: rtl/clock_time_setting_editor_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Beat contents
// in_*      in         tuser: command; tdata: year, month, day, hour, minute, second
// out_*     out        tuser: save strobe; tdata: time, cursor, display hour, PM flag
// cfg_*     in         twelve_hour_mode, written when cfg_wr_en is high
//
// One beat is accepted per cycle unless a stall on out_tready backs up.
// The input register and the result register each take one beat, and the
// edit state is updated in the single combinational pass between them.
// A stall on out_tready holds the result; in_tready drops only when both
// registers are full. Synchronous reset loads 1900-01-01 00:00:00, hour
// selected, 24-hour mode.

`include "clock_time_setting_editor_unit_defines.svh"

module clock_time_setting_editor_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Configuration write port.
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_wr_data,
  // Input beats.
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // tdata: [11:0] load_year, [15:12] load_month, [20:16] load_day,
  //        [25:21] load_hour, [31:26] load_minute, [37:32] load_second, [39:38] zero
  input  wire logic [ctse_pkg::IN_DATA_W-1:0] in_tdata,
  // tuser: [2:0] command
  input  wire logic [2:0]  in_tuser,
  // Result beats.
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // tdata: [11:0] out_year, [15:12] out_month, [20:16] out_day,
  //        [25:21] out_hour, [31:26] out_minute, [37:32] out_second,
  //        [40:38] selected_field, [45:41] display_hour, [46] pm_flag, [47] zero
  output logic [ctse_pkg::OUT_DATA_W-1:0] out_tdata,
  // tuser: [0] save_strobe
  output logic             out_tuser
);

  // Configuration register.
  logic        twelve_hour_r;

  // Input register.
  logic        s1_valid_r;
  logic [2:0]  s1_cmd_r;
  logic [37:0] s1_data_r;

  // Edit state.
  logic [11:0] edit_year_r,   edit_year_nxt;
  logic [3:0]  edit_month_r,  edit_month_nxt;
  logic [4:0]  edit_day_r,    edit_day_nxt;
  logic [4:0]  edit_hour_r,   edit_hour_nxt;
  logic [5:0]  edit_minute_r, edit_minute_nxt;
  logic [5:0]  edit_second_r, edit_second_nxt;
  logic [2:0]  edit_cursor_r, edit_cursor_nxt;

  // Result register.
  logic        out_valid_r;
  logic [4:0]  out_dhour_r,   out_dhour_nxt;
  logic        out_pm_r,      out_pm_nxt;
  logic        out_save_r,    out_save_nxt;

  // Handshake.
  logic        out_adv;
  logic        s1_fire;
  logic        in_fire;

  // Loaded fields after folding into range.
  logic [11:0] ld_year;
  logic [3:0]  ld_month;
  logic [4:0]  ld_day_raw;
  logic [4:0]  ld_dim;
  logic [4:0]  ld_hour;
  logic [5:0]  ld_minute;
  logic [5:0]  ld_second;

  // Intermediate day before the month-length check.
  logic [4:0]  cur_dim;
  logic [4:0]  day_pre;
  logic [4:0]  new_dim;

  assign out_adv   = !out_valid_r || out_tready;
  assign s1_fire   = s1_valid_r && out_adv;
  assign in_tready = !s1_valid_r || out_adv;
  assign in_fire   = in_tvalid && in_tready;

  // Fold loaded values: above the top gives the bottom, below gives the top.
  assign ld_year = (s1_data_r[11:0] > ctse_pkg::LAST_YEAR)  ? ctse_pkg::FIRST_YEAR :
                   (s1_data_r[11:0] < ctse_pkg::FIRST_YEAR) ? ctse_pkg::LAST_YEAR  :
                   s1_data_r[11:0];
  assign ld_month = (s1_data_r[15:12] > ctse_pkg::LAST_MONTH)  ? ctse_pkg::FIRST_MONTH :
                    (s1_data_r[15:12] < ctse_pkg::FIRST_MONTH) ? ctse_pkg::LAST_MONTH  :
                    s1_data_r[15:12];
  assign ld_dim     = ctse_pkg::days_of(ld_year, ld_month);
  assign ld_day_raw = s1_data_r[20:16];
  assign ld_hour    = (s1_data_r[25:21] > ctse_pkg::LAST_HOUR) ? 5'd0 : s1_data_r[25:21];
  assign ld_minute  = (s1_data_r[31:26] > ctse_pkg::LAST_MINSEC) ? 6'd0 : s1_data_r[31:26];
  assign ld_second  = (s1_data_r[37:32] > ctse_pkg::LAST_MINSEC) ? 6'd0 : s1_data_r[37:32];

  assign cur_dim = ctse_pkg::days_of(edit_year_r, edit_month_r);

  // Command decode and field stepping.
  always_comb begin
    edit_year_nxt   = edit_year_r;
    edit_month_nxt  = edit_month_r;
    day_pre         = edit_day_r;
    edit_hour_nxt   = edit_hour_r;
    edit_minute_nxt = edit_minute_r;
    edit_second_nxt = edit_second_r;
    edit_cursor_nxt = edit_cursor_r;
    out_save_nxt    = 1'b0;
    case (s1_cmd_r)
      ctse_pkg::CMD_LOAD: begin
        edit_year_nxt   = ld_year;
        edit_month_nxt  = ld_month;
        day_pre         = (ld_day_raw > ld_dim) ? ctse_pkg::FIRST_DAY :
                          (ld_day_raw < ctse_pkg::FIRST_DAY) ? ld_dim : ld_day_raw;
        edit_hour_nxt   = ld_hour;
        edit_minute_nxt = ld_minute;
        edit_second_nxt = ld_second;
        edit_cursor_nxt = ctse_pkg::FLD_HOUR;
      end
      ctse_pkg::CMD_NEXT: begin
        edit_cursor_nxt = (edit_cursor_r >= ctse_pkg::FLD_DAY) ? ctse_pkg::FLD_HOUR :
                          edit_cursor_r + 3'd1;
      end
      ctse_pkg::CMD_INC: begin
        case (edit_cursor_r)
          ctse_pkg::FLD_HOUR:
            edit_hour_nxt = (edit_hour_r >= ctse_pkg::LAST_HOUR) ? 5'd0 : edit_hour_r + 5'd1;
          ctse_pkg::FLD_MINUTE:
            edit_minute_nxt = (edit_minute_r >= ctse_pkg::LAST_MINSEC) ? 6'd0 :
                              edit_minute_r + 6'd1;
          ctse_pkg::FLD_SECOND:
            edit_second_nxt = (edit_second_r >= ctse_pkg::LAST_MINSEC) ? 6'd0 :
                              edit_second_r + 6'd1;
          ctse_pkg::FLD_YEAR:
            edit_year_nxt = (edit_year_r >= ctse_pkg::LAST_YEAR) ? ctse_pkg::FIRST_YEAR :
                            edit_year_r + 12'd1;
          ctse_pkg::FLD_MONTH:
            edit_month_nxt = (edit_month_r >= ctse_pkg::LAST_MONTH) ? ctse_pkg::FIRST_MONTH :
                             edit_month_r + 4'd1;
          default:
            day_pre = (edit_day_r >= cur_dim) ? ctse_pkg::FIRST_DAY : edit_day_r + 5'd1;
        endcase
      end
      ctse_pkg::CMD_DEC: begin
        case (edit_cursor_r)
          ctse_pkg::FLD_HOUR:
            edit_hour_nxt = (edit_hour_r == 5'd0) ? ctse_pkg::LAST_HOUR : edit_hour_r - 5'd1;
          ctse_pkg::FLD_MINUTE:
            edit_minute_nxt = (edit_minute_r == 6'd0) ? ctse_pkg::LAST_MINSEC :
                              edit_minute_r - 6'd1;
          ctse_pkg::FLD_SECOND:
            edit_second_nxt = (edit_second_r == 6'd0) ? ctse_pkg::LAST_MINSEC :
                              edit_second_r - 6'd1;
          ctse_pkg::FLD_YEAR:
            edit_year_nxt = (edit_year_r <= ctse_pkg::FIRST_YEAR) ? ctse_pkg::LAST_YEAR :
                            edit_year_r - 12'd1;
          ctse_pkg::FLD_MONTH:
            edit_month_nxt = (edit_month_r <= ctse_pkg::FIRST_MONTH) ? ctse_pkg::LAST_MONTH :
                             edit_month_r - 4'd1;
          default:
            day_pre = (edit_day_r <= ctse_pkg::FIRST_DAY) ? cur_dim : edit_day_r - 5'd1;
        endcase
      end
      ctse_pkg::CMD_SAVE: begin
        out_save_nxt = 1'b1;
      end
      default: begin
        out_save_nxt = 1'b0;
      end
    endcase
  end

  // A day past the end of the (possibly new) month falls to the first.
  assign new_dim      = ctse_pkg::days_of(edit_year_nxt, edit_month_nxt);
  assign edit_day_nxt = (day_pre > new_dim) ? ctse_pkg::FIRST_DAY : day_pre;

  // Hour as displayed, with the PM flag in twelve-hour mode.
  always_comb begin
    out_dhour_nxt = edit_hour_nxt;
    out_pm_nxt    = 1'b0;
    if (twelve_hour_r) begin
      if (edit_hour_nxt >= ctse_pkg::NOON_HOUR) begin
        out_pm_nxt = 1'b1;
        if (edit_hour_nxt > ctse_pkg::NOON_HOUR) begin
          out_dhour_nxt = edit_hour_nxt - ctse_pkg::NOON_HOUR;
        end
      end else if (edit_hour_nxt == 5'd0) begin
        out_dhour_nxt = ctse_pkg::NOON_HOUR;
      end
    end
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      twelve_hour_r <= 1'b0;
    end else if (cfg_wr_en) begin
      twelve_hour_r <= cfg_wr_data;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cmd_r  <= in_tuser;
      s1_data_r <= in_tdata[37:0];
    end
  end

  // Edit state, updated once per beat that moves into the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      edit_year_r   <= ctse_pkg::FIRST_YEAR;
      edit_month_r  <= ctse_pkg::FIRST_MONTH;
      edit_day_r    <= ctse_pkg::FIRST_DAY;
      edit_hour_r   <= 5'd0;
      edit_minute_r <= 6'd0;
      edit_second_r <= 6'd0;
      edit_cursor_r <= ctse_pkg::FLD_HOUR;
    end else if (s1_fire) begin
      edit_year_r   <= edit_year_nxt;
      edit_month_r  <= edit_month_nxt;
      edit_day_r    <= edit_day_nxt;
      edit_hour_r   <= edit_hour_nxt;
      edit_minute_r <= edit_minute_nxt;
      edit_second_r <= edit_second_nxt;
      edit_cursor_r <= edit_cursor_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_dhour_r <= out_dhour_nxt;
      out_pm_r    <= out_pm_nxt;
      out_save_r  <= out_save_nxt;
    end
  end

  // The edit state doubles as the time and cursor fields of the result.
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_save_r;
  assign out_tdata  = {1'b0, out_pm_r, out_dhour_r, edit_cursor_r, edit_second_r,
                       edit_minute_r, edit_hour_r, edit_day_r, edit_month_r, edit_year_r};

  // Checks on the edit state and the result register.
  `CTSE_ASSERT(a_year_in_span, (edit_year_r >= ctse_pkg::FIRST_YEAR) && (edit_year_r <= ctse_pkg::LAST_YEAR))
  `CTSE_ASSERT(a_day_in_month, (edit_day_r != 5'd0) && (edit_day_r <= ctse_pkg::days_of(edit_year_r, edit_month_r)))
  `CTSE_ASSERT(a_cursor_range, edit_cursor_r <= ctse_pkg::FLD_DAY)
  `CTSE_ASSERT(a_pm_hour, (out_valid_r && out_pm_r) |-> (edit_hour_r >= ctse_pkg::NOON_HOUR))
  `CTSE_ASSERT(a_stall_holds_state, (out_valid_r && !out_tready) |=> ($stable(edit_year_r) && $stable(edit_cursor_r) && $stable(edit_day_r)))

endmodule

`default_nettype wire

// File: test/clock_time_setting_editor_unit_checker.sv
`timescale 1ns / 1ps

// Watches the command, result and mode-write ports of the editor, keeps its
// own copy of the edited time, and compares every result beat with the view
// predicted for the oldest outstanding command.
module clock_time_setting_editor_unit_checker
  import ctse_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic                  cfg_wr_data,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic [2:0]            in_tuser,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  out_tuser,
  output int                    fail_count,
  output int                    pending_results
);

  // Everything one result beat shows.
  typedef struct {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [2:0]  cursor;
    logic [4:0]  shown_hour;
    logic        pm;
    logic        save;
  } editor_view_t;

  editor_view_t expected_views[$];
  editor_view_t oldest_view;

  // Predicted edit state and the display mode.
  logic [11:0] ed_year;
  logic [3:0]  ed_month;
  logic [4:0]  ed_day;
  logic [4:0]  ed_hour;
  logic [5:0]  ed_minute;
  logic [5:0]  ed_second;
  logic [2:0]  ed_cursor;
  logic        twelve_hour;

  initial begin
    fail_count = 0;
    pending_results = 0;
  end

  // Full Gregorian rule: every fourth year, except centuries not divisible by 400.
  function automatic bit gregorian_leap(int y);
    return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
  endfunction

  function automatic int month_length(int y, int m);
    case (m)
      2:             return gregorian_leap(y) ? 29 : 28;
      4, 6, 9, 11:   return 30;
      default:       return 31;
    endcase
  endfunction

  // A loaded value above the range falls to the bottom, below it to the top.
  function automatic int wrap_into(int v, int lo, int hi);
    if (v > hi) return lo;
    if (v < lo) return hi;
    return v;
  endfunction

  // One step up or down inside [lo, hi], wrapping at both ends.
  function automatic int step_wrap(int v, int lo, int hi, bit up);
    if (up) return (v >= hi) ? lo : v + 1;
    return (v <= lo) ? hi : v - 1;
  endfunction

  // Update the edit state for one accepted command beat.
  task automatic apply_command(input logic [2:0] cmd, input logic [IN_DATA_W-1:0] d);
    bit up;
    up = (cmd == CMD_INC);
    case (cmd)
      CMD_LOAD: begin
        ed_year   = 12'(wrap_into(d[11:0], FIRST_YEAR, LAST_YEAR));
        ed_month  = 4'(wrap_into(d[15:12], FIRST_MONTH, LAST_MONTH));
        ed_day    = 5'(wrap_into(d[20:16], FIRST_DAY, month_length(ed_year, ed_month)));
        ed_hour   = 5'(wrap_into(d[25:21], 0, LAST_HOUR));
        ed_minute = 6'(wrap_into(d[31:26], 0, LAST_MINSEC));
        ed_second = 6'(wrap_into(d[37:32], 0, LAST_MINSEC));
        ed_cursor = FLD_HOUR;
      end
      CMD_NEXT: ed_cursor = (ed_cursor >= FLD_DAY) ? FLD_HOUR : ed_cursor + 3'd1;
      CMD_INC, CMD_DEC: begin
        case (ed_cursor)
          FLD_HOUR:   ed_hour   = 5'(step_wrap(ed_hour, 0, LAST_HOUR, up));
          FLD_MINUTE: ed_minute = 6'(step_wrap(ed_minute, 0, LAST_MINSEC, up));
          FLD_SECOND: ed_second = 6'(step_wrap(ed_second, 0, LAST_MINSEC, up));
          FLD_YEAR:   ed_year   = 12'(step_wrap(ed_year, FIRST_YEAR, LAST_YEAR, up));
          FLD_MONTH:  ed_month  = 4'(step_wrap(ed_month, FIRST_MONTH, LAST_MONTH, up));
          default:
            ed_day = 5'(step_wrap(ed_day, FIRST_DAY, month_length(ed_year, ed_month), up));
        endcase
        // A month or year change can leave the day past the month's end.
        if (ed_day > month_length(ed_year, ed_month)) ed_day = FIRST_DAY;
      end
      default: ;
    endcase
  endtask

  function automatic editor_view_t current_view(logic save);
    editor_view_t v;
    v.year = ed_year;
    v.month = ed_month;
    v.day = ed_day;
    v.hour = ed_hour;
    v.minute = ed_minute;
    v.second = ed_second;
    v.cursor = ed_cursor;
    v.save = save;
    v.shown_hour = ed_hour;
    v.pm = 1'b0;
    // Twelve-hour display: midnight shows as 12, afternoon hours drop by 12.
    if (twelve_hour) begin
      if (ed_hour >= NOON_HOUR) begin
        v.pm = 1'b1;
        if (ed_hour > NOON_HOUR) v.shown_hour = ed_hour - NOON_HOUR;
      end else if (ed_hour == 5'd0) begin
        v.shown_hour = NOON_HOUR;
      end
    end
    return v;
  endfunction

  task automatic check_field(input string name, input logic [11:0] want,
                             input logic [11:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // Results are compared before the command of the same edge is predicted;
  // the block's latency keeps the two apart.
  always @(posedge clk) begin
    if (!rst_n) begin
      ed_year = FIRST_YEAR;
      ed_month = FIRST_MONTH;
      ed_day = FIRST_DAY;
      ed_hour = 5'd0;
      ed_minute = 6'd0;
      ed_second = 6'd0;
      ed_cursor = FLD_HOUR;
      twelve_hour = 1'b0;
      expected_views.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_views.size() == 0) begin
          $error("result beat arrived with no command outstanding");
          fail_count++;
        end else begin
          oldest_view = expected_views.pop_front();
          check_field("out_year", oldest_view.year, out_tdata[11:0]);
          check_field("out_month", oldest_view.month, out_tdata[15:12]);
          check_field("out_day", oldest_view.day, out_tdata[20:16]);
          check_field("out_hour", oldest_view.hour, out_tdata[25:21]);
          check_field("out_minute", oldest_view.minute, out_tdata[31:26]);
          check_field("out_second", oldest_view.second, out_tdata[37:32]);
          check_field("selected_field", oldest_view.cursor, out_tdata[40:38]);
          check_field("display_hour", oldest_view.shown_hour, out_tdata[45:41]);
          check_field("pm_flag", oldest_view.pm, out_tdata[46]);
          check_field("tdata_pad", 12'd0, out_tdata[47]);
          check_field("save_strobe", oldest_view.save, out_tuser);
        end
      end
      if (cfg_wr_en) twelve_hour = cfg_wr_data;
      if (in_tvalid && in_tready) begin
        apply_command(in_tuser, in_tdata);
        expected_views.push_back(current_view(in_tuser == CMD_SAVE));
      end
    end
    pending_results = expected_views.size();
  end

endmodule

// File: test/clock_time_setting_editor_unit_test.sv
`timescale 1ns / 1ps

// Drives key commands into the editor, stalls both sides at random, and
// leaves prediction and comparison to the checker beside the block.
module clock_time_setting_editor_unit_test;
  import ctse_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD      = 200;
  localparam int PHASES         = 8;
  localparam int PHASE_BEATS    = 100;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic                  cfg_wr_data = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [2:0]            in_tuser = CMD_LOAD;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;

  int fail_count;
  int pending_results;
  int idle_cycles = 0;
  bit hold_request = 1'b0;
  bit sender_burst = 1'b0;
  bit receiver_burst = 1'b0;
  int ready_gap;

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  clock_time_setting_editor_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  clock_time_setting_editor_unit_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .fail_count     (fail_count),
    .pending_results(pending_results)
  );

  // Ends the run when no beat moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side: a random wait before each beat, runs without waits, and one
  // long hold-off on request.
  initial begin
    wait (rst_n);
    forever begin
      if (hold_request) begin
        out_tready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_request = 1'b0;
      end
      ready_gap = receiver_burst ? 0 : $urandom_range(0, 7);
      if ($urandom_range(0, 19) == 0) receiver_burst = !receiver_burst;
      if (ready_gap != 0) begin
        out_tready = 1'b0;
        repeat (ready_gap) @(negedge clk);
      end
      out_tready = 1'b1;
      do @(posedge clk); while (!out_tvalid);
      @(negedge clk);
    end
  end

  // Offer one command beat after a random gap and hold it until accepted.
  task automatic send_command(input logic [2:0] cmd, input int yr, input int mo,
                              input int dy, input int hr, input int mi, input int se);
    int gap;
    gap = sender_burst ? 0 : $urandom_range(0, 7);
    if ($urandom_range(0, 19) == 0) sender_burst = !sender_burst;
    if (gap != 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tuser = cmd;
    in_tdata = {2'b00, 6'(se), 6'(mi), 5'(hr), 5'(dy), 4'(mo), 12'(yr)};
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // Commands other than load carry noise in the time fields.
  task automatic send_key(input logic [2:0] cmd);
    send_command(cmd, $urandom_range(0, 4095), $urandom_range(0, 15), $urandom_range(0, 31),
                 $urandom_range(0, 31), $urandom_range(0, 63), $urandom_range(0, 63));
  endtask

  // Stop sending and wait until every result is back.
  task automatic settle();
    in_tvalid = 1'b0;
    while (pending_results != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_mode(input logic twelve);
    cfg_wr_data = twelve;
    cfg_wr_en = 1'b1;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  // Mostly edit keys on loaded times near the interesting edges, with some
  // out-of-range loads, saves and unused command codes mixed in.
  task automatic random_command();
    int pick;
    int yr;
    int mo;
    int dy;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      if ($urandom_range(0, 3) == 0) begin
        send_command(CMD_LOAD, $urandom_range(0, 4095), $urandom_range(0, 15),
                     $urandom_range(0, 31), $urandom_range(0, 31),
                     $urandom_range(0, 63), $urandom_range(0, 63));
      end else begin
        case ($urandom_range(0, 3))
          0:       yr = $urandom_range(2096, 2100);
          1:       yr = $urandom_range(1900, 1904);
          2:       yr = $urandom_range(1996, 2004);
          default: yr = $urandom_range(1900, 2100);
        endcase
        mo = ($urandom_range(0, 2) == 0) ? 2 : $urandom_range(1, 12);
        dy = ($urandom_range(0, 1) == 0) ? $urandom_range(27, 31) : $urandom_range(1, 31);
        send_command(CMD_LOAD, yr, mo, dy, $urandom_range(0, 23),
                     $urandom_range(0, 59), $urandom_range(0, 59));
      end
    end else if (pick < 30) begin
      send_key(CMD_NEXT);
    end else if (pick < 60) begin
      send_key(CMD_INC);
    end else if (pick < 88) begin
      send_key(CMD_DEC);
    end else if (pick < 94) begin
      send_key(CMD_SAVE);
    end else begin
      // Codes past save are unused.
      send_key(3'(CMD_SAVE) + 3'($urandom_range(1, 3)));
    end
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed edges, shown in twelve-hour form.
    write_mode(1'b1);
    send_command(CMD_LOAD, 4095, 15, 31, 31, 63, 63);  // all fields but the day above range
    send_command(CMD_LOAD, 0, 0, 0, 0, 0, 0);           // date fields below range, time at zero
    send_key(CMD_DEC);                                  // hour 0 wraps to 23
    send_key(CMD_INC);                                  // and back to midnight
    send_command(CMD_LOAD, 2000, 2, 29, 12, 59, 59);    // leap day, noon
    send_key(CMD_NEXT);
    send_key(CMD_INC);                                  // minute 59 wraps to 0
    send_key(CMD_NEXT);
    send_key(CMD_INC);                                  // second 59 wraps to 0
    send_key(CMD_NEXT);
    send_key(CMD_INC);                                  // 2001 has no Feb 29
    send_key(CMD_NEXT);
    send_key(CMD_DEC);
    send_key(CMD_NEXT);
    send_key(CMD_DEC);                                  // day 1 wraps to month end
    send_key(CMD_NEXT);                                 // cursor wraps to hour
    send_command(CMD_LOAD, 2100, 12, 31, 13, 0, 0);
    send_key(CMD_NEXT);
    send_key(CMD_NEXT);
    send_key(CMD_NEXT);
    send_key(CMD_INC);                                  // top year wraps to bottom
    send_key(CMD_DEC);                                  // and bottom to top
    send_key(CMD_SAVE);
    send_key(3'(CMD_SAVE) + 3'd3);
    send_command(CMD_LOAD, 1900, 2, 29, 11, 30, 30);    // 1900 is not a leap year

    // Random phases, alternating the display mode.
    for (int phase = 0; phase < PHASES; phase++) begin
      settle();
      write_mode(phase[0]);
      if (phase == 3) begin
        hold_request = 1'b1;
        sender_burst = 1'b1;
      end
      repeat (PHASE_BEATS) random_command();
    end

    settle();
    repeat (6) @(negedge clk);
    if (fail_count == 0 && pending_results == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/ctse_pkg.sv
rtl/clock_time_setting_editor_unit.sv
test/clock_time_setting_editor_unit_checker.sv
test/clock_time_setting_editor_unit_test.sv
